>>> sv/kpc_pkg.sv
`timescale 1ns / 1ps
package kpc_pkg;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_STORE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	localparam logic [7:0] CFG_CAPACITY = 8'd0;
	localparam logic [7:0] CFG_HOT      = 8'd1;

	localparam logic [5:0]  CAP_RESET = 6'd32;
	localparam logic [31:0] HOT_RESET = 32'h0000_2710;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_UPD  = 4'b0100,
		ST_OUT  = 4'b1000
	} kpc_state_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic upd;
	} kpc_cmd_t;

endpackage

>>> sv/keyed_position_cache.sv
`timescale 1ns / 1ps
// The input is registered on transfer, then the compare and update states run before
// the result is offered in the output state.
// A new item is taken only once the result of the last one has been taken; the pace is
// set by the compare/update sequence over the entry cells.
// Reset: table empty, counters and victim zero, capacity 32, hot threshold 10000.
module keyed_position_cache #(
	parameter int DEPTH    = 32,
	parameter int TAG_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] file_tag,
	input  logic [63:0] label_tag,
	input  logic [63:0] position_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [63:0] position_out,
	output logic        evicted,
	output logic [31:0] hit_total,
	output logic [31:0] miss_total,
	output logic [5:0]  fill_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import kpc_pkg::*;

	kpc_cmd_t cmd;

	assign cfg_ready = 1'b1;

	kpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	kpc_datapath #(
		.DEPTH    (DEPTH),
		.TAG_BITS (TAG_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.file_tag     (file_tag),
		.label_tag    (label_tag),
		.position_in  (position_in),
		.found        (found),
		.position_out (position_out),
		.evicted      (evicted),
		.hit_total    (hit_total),
		.miss_total   (miss_total),
		.fill_level   (fill_level)
	);

endmodule

>>> sv/kpc_ctrl.sv
`timescale 1ns / 1ps
module kpc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output kpc_pkg::kpc_cmd_t  cmd
);
	import kpc_pkg::*;

	kpc_state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CMP;
			ST_CMP:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.load  = in_valid && (state_q == ST_IDLE);
	assign cmd.cmp   = (state_q == ST_CMP);
	assign cmd.upd   = (state_q == ST_UPD);

endmodule

>>> sv/kpc_datapath.sv
`timescale 1ns / 1ps
module kpc_datapath #(
	parameter int DEPTH    = 32,
	parameter int TAG_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kpc_pkg::kpc_cmd_t cmd,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [1:0]        action,
	input  logic [63:0]       file_tag,
	input  logic [63:0]       label_tag,
	input  logic [63:0]       position_in,
	output logic              found,
	output logic [63:0]       position_out,
	output logic              evicted,
	output logic [31:0]       hit_total,
	output logic [31:0]       miss_total,
	output logic [5:0]        fill_level
);
	import kpc_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [TAG_BITS-1:0] ft_q  [DEPTH];
	logic [TAG_BITS-1:0] lt_q  [DEPTH];
	logic [63:0]         pos_q [DEPTH];
	logic [31:0]         use_q [DEPTH];

	logic [CW-1:0]  total_q;
	logic [IW-1:0]  victim_q;
	logic [31:0]    hits_q, misses_q;
	logic [5:0]     cap_q;
	logic [31:0]    hot_q;

	logic [1:0]          act_q;
	logic [TAG_BITS-1:0] ift_q, ilt_q;
	logic [63:0]         ipos_q;

	logic [DEPTH-1:0] match_s1, below_s1;

	logic              found_q, evicted_q;
	logic [63:0]       posout_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			hot_q <= HOT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_CAPACITY) cap_q <= cfg_data[5:0];
			if (cfg_index == CFG_HOT)      hot_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			ift_q  <= file_tag[TAG_BITS-1:0];
			ilt_q  <= label_tag[TAG_BITS-1:0];
			ipos_q <= position_in;
		end
	end

	// parallel compare across all valid entries
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			for (int i = 0; i < DEPTH; i++) begin
				match_s1[i] <= (32'(i) < 32'(total_q)) && ft_q[i] == ift_q && lt_q[i] == ilt_q;
				below_s1[i] <= (32'(i) < 32'(total_q)) && use_q[i] < hot_q;
			end
		end
	end

	logic           hit;
	logic [IW-1:0]  hit_idx, vic_new, vic_eff;
	logic [31:0]    eff_cap, cap32, total32;
	logic           evict;
	logic [CW-1:0]  new_idx;
	logic           is_lookup, is_store;

	always_comb begin
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_s1[i]) hit_idx = IW'(i);
		end
		hit = |match_s1;
		vic_new = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (below_s1[i] && (!hit || IW'(i) < hit_idx)) vic_new = IW'(i);
		end
		cap32   = {26'd0, cap_q};
		total32 = 32'(total_q);
		if (cap_q == 6'd0) eff_cap = 32'd1;
		else if (cap32 > 32'(DEPTH)) eff_cap = 32'(DEPTH);
		else eff_cap = cap32;
		evict   = (total32 >= eff_cap) && (total_q != '0);
		vic_eff = (32'(victim_q) >= total32) ? '0 : victim_q;
		new_idx = evict ? total_q - CW'(1) : total_q;
		is_lookup = cmd.upd && act_q == ACT_LOOKUP;
		is_store  = cmd.upd && act_q == ACT_STORE;
	end

	// entry cells: shift down over the victim, append at tail, bump use count
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic shift_in;
		if (g < DEPTH - 1) begin : g_sh
			assign shift_in = evict && IW'(g) >= vic_eff && 32'(g + 1) < total32;
		end else begin : g_nosh
			assign shift_in = 1'b0;
		end
		always_ff @(posedge clk) begin
			if (is_store) begin
				if (32'(g) == 32'(new_idx)) begin
					ft_q[g]  <= ift_q;
					lt_q[g]  <= ilt_q;
					pos_q[g] <= ipos_q;
					use_q[g] <= '0;
				end else if (shift_in) begin
					ft_q[g]  <= ft_q[(g + 1) % DEPTH];
					lt_q[g]  <= lt_q[(g + 1) % DEPTH];
					pos_q[g] <= pos_q[(g + 1) % DEPTH];
					use_q[g] <= use_q[(g + 1) % DEPTH];
				end
			end else if (is_lookup && hit && hit_idx == IW'(g)) begin
				if (use_q[g] != '1) use_q[g] <= use_q[g] + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			victim_q <= '0;
			hits_q   <= '0;
			misses_q <= '0;
		end else if (cmd.upd) begin
			case (act_q)
				ACT_LOOKUP: begin
					victim_q <= vic_new;
					if (hit) hits_q <= hits_q + 32'd1;
					else misses_q <= misses_q + 32'd1;
				end
				ACT_STORE: begin
					if (evict) victim_q <= '0;
					else total_q <= total_q + CW'(1);
				end
				ACT_CLEAR: begin
					total_q  <= '0;
					victim_q <= '0;
					hits_q   <= '0;
					misses_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			found_q   <= is_lookup && hit;
			posout_q  <= (is_lookup && hit) ? pos_q[hit_idx] : '1;
			evicted_q <= is_store && evict;
		end
	end

	assign found        = found_q;
	assign position_out = posout_q;
	assign evicted      = evicted_q;
	assign hit_total    = hits_q;
	assign miss_total   = misses_q;
	assign fill_level   = total32[5:0];

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import kpc_pkg::*;

	typedef struct {
		logic [1:0]  act;
		logic [63:0] ftag;
		logic [63:0] ltag;
		logic [63:0] pos;
	} access_t;

	typedef struct {
		logic        hit;
		logic [63:0] pos;
		logic        ev;
		logic [31:0] hits;
		logic [31:0] misses;
		logic [5:0]  fill;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [63:0] file_tag;
	logic [63:0] label_tag;
	logic [63:0] position_in;
	logic        out_valid;
	logic        out_ready;
	logic        found;
	logic [63:0] position_out;
	logic        evicted;
	logic [31:0] hit_total;
	logic [31:0] miss_total;
	logic [5:0]  fill_level;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [31:0] cfg_data;

	keyed_position_cache DUT (.*);

	// predictor state
	logic [63:0] m_ftag [32];
	logic [63:0] m_ltag [32];
	logic [63:0] m_pos [32];
	logic [31:0] m_uses [32];
	int unsigned m_fill;
	int unsigned m_victim;
	logic [31:0] m_hits;
	logic [31:0] m_misses;
	logic [5:0]  m_cap;
	logic [31:0] m_hot;

	access_t pending_accesses[$];
	reply_t  expected_replies[$];
	int      send_idle;
	int      recv_idle;
	int      mismatches;
	int      cycles;
	bit      hold_off;

	function automatic reply_t predict_access(access_t a);
		reply_t r;
		int unsigned cap;
		int unsigned v;
		r.hit = 0;
		r.pos = '1;
		r.ev = 0;
		if (a.act == ACT_LOOKUP) begin
			m_victim = 0;
			for (int i = 0; i < m_fill; i++) begin
				if (m_ftag[i] == a.ftag && m_ltag[i] == a.ltag) begin
					r.hit = 1;
					r.pos = m_pos[i];
					if (m_uses[i] != '1)
						m_uses[i]++;
					break;
				end
				if (m_uses[i] < m_hot)
					m_victim = i;
			end
			if (r.hit)
				m_hits++;
			else
				m_misses++;
		end else if (a.act == ACT_STORE) begin
			cap = (m_cap < 1) ? 1 : (m_cap > 32) ? 32 : m_cap;
			if (m_fill >= cap && m_fill > 0) begin
				v = (m_victim >= m_fill) ? 0 : m_victim;
				for (int i = v; i + 1 < m_fill; i++) begin
					m_ftag[i] = m_ftag[i+1];
					m_ltag[i] = m_ltag[i+1];
					m_pos[i] = m_pos[i+1];
					m_uses[i] = m_uses[i+1];
				end
				m_fill--;
				m_victim = 0;
				r.ev = 1;
			end
			m_ftag[m_fill] = a.ftag;
			m_ltag[m_fill] = a.ltag;
			m_pos[m_fill] = a.pos;
			m_uses[m_fill] = 0;
			m_fill++;
		end else if (a.act == ACT_CLEAR) begin
			m_fill = 0;
			m_victim = 0;
			m_hits = 0;
			m_misses = 0;
		end
		r.hits = m_hits;
		r.misses = m_misses;
		r.fill = m_fill[5:0];
		return r;
	endfunction

	task automatic queue_access(logic [1:0] act, logic [63:0] f, logic [63:0] l, logic [63:0] p);
		access_t a;
		a.act = act;
		a.ftag = f;
		a.ltag = l;
		a.pos = p;
		pending_accesses.push_back(a);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// small key pool so lookups hit often
	task automatic queue_random(int count);
		int k;
		int r;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 11);
			r = $urandom_range(0, 99);
			if (r < 55)
				queue_access(ACT_LOOKUP, 64'hF000 + k, 64'h1000 + (k % 5),
					rand64());
			else if (r < 90)
				queue_access(ACT_STORE, 64'hF000 + k, 64'h1000 + (k % 5),
					rand64());
			else if (r < 93)
				queue_access(ACT_CLEAR, rand64(), rand64(), rand64());
			else if (r < 96)
				queue_access(2'd3, rand64(), rand64(), rand64());
			else
				queue_access(2'($urandom_range(0, 1)), rand64(), rand64(), rand64());
		end
	endtask

	// check between edges so a popped item not yet driven is still seen
	task automatic drain();
		@(negedge clk);
		while (pending_accesses.size() != 0 || expected_replies.size() != 0 || in_valid)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		if (idx == CFG_CAPACITY)
			m_cap = val[5:0];
		else if (idx == CFG_HOT)
			m_hot = val;
		@(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_replies.push_back(predict_access('{action, file_tag,
					label_tag, position_in}));
			end
			if (!in_valid || in_ready) begin
				if (pending_accesses.size() != 0 && !hold_off
					&& $urandom_range(0, 99) >= send_idle) begin
					access_t a;
					a = pending_accesses.pop_front();
					action <= a.act;
					file_tag <= a.ftag;
					label_tag <= a.ltag;
					position_in <= a.pos;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer");
				end else begin
					reply_t e;
					e = expected_replies.pop_front();
					if (found !== e.hit || position_out !== e.pos || evicted !== e.ev
						|| hit_total !== e.hits || miss_total !== e.misses
						|| fill_level !== e.fill) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %b %h %b %0d %0d %0d got %b %h %b %0d %0d %0d",
								e.hit, e.pos, e.ev, e.hits, e.misses, e.fill, found,
								position_out, evicted, hit_total, miss_total, fill_level);
					end
				end
			end
			out_ready <= $urandom_range(0, 99) >= recv_idle;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		in_valid = 0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		action = '0;
		file_tag = '0;
		label_tag = '0;
		position_in = '0;
		m_fill = 0;
		m_victim = 0;
		m_hits = 0;
		m_misses = 0;
		m_cap = CAP_RESET;
		m_hot = HOT_RESET;
		mismatches = 0;
		cycles = 0;
		hold_off = 0;
		send_idle = 36;
		recv_idle = 68;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every action, duplicates, unused code
		queue_access(ACT_LOOKUP, '0, '0, '0);
		queue_access(ACT_STORE, '0, '0, '0);
		queue_access(ACT_STORE, '1, '1, '1);
		queue_access(ACT_STORE, '1, '1, 64'h5555_AAAA_0F0F_F0F0);
		queue_access(ACT_LOOKUP, '1, '1, '0);
		queue_access(ACT_LOOKUP, '0, '0, '1);
		queue_access(ACT_LOOKUP, '1, '0, '0);
		queue_access(2'd3, '1, '1, '1);
		queue_access(ACT_CLEAR, '1, '1, '1);
		queue_access(ACT_LOOKUP, '1, '1, '1);
		drain();

		// tiny capacity and zero capacity clamp, hot threshold zero
		write_reg(CFG_CAPACITY, 32'd2);
		write_reg(CFG_HOT, 32'd0);
		for (int i = 0; i < 5; i++)
			queue_access(ACT_STORE, 64'hA0 + i, 64'hB0, rand64());
		queue_access(ACT_LOOKUP, 64'hA4, 64'hB0, '0);
		queue_access(ACT_LOOKUP, 64'hA9, 64'hB0, '0);
		queue_access(ACT_STORE, 64'hAA, 64'hB0, '0);
		drain();
		write_reg(CFG_CAPACITY, 32'd0);
		write_reg(CFG_HOT, 32'hFFFF_FFFF);
		queue_access(ACT_STORE, 64'hC1, 64'hC2, '1);
		queue_access(ACT_STORE, 64'hC3, 64'hC4, '0);
		drain();

		write_reg(CFG_CAPACITY, 32'd8);
		write_reg(CFG_HOT, 32'd2);
		queue_random(600);
		drain();

		// wait out every result once with the sender held off
		hold_off = 1;
		drain();
		hold_off = 0;

		send_idle = 68;
		recv_idle = 36;
		write_reg(CFG_CAPACITY, 32'd63);
		write_reg(CFG_HOT, 32'd1);
		queue_random(600);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_reg(CFG_CAPACITY, 32'd32);
		write_reg(CFG_HOT, 32'd10000);
		queue_random(300);
		drain();
		write_reg(CFG_CAPACITY, 32'd1);
		write_reg(CFG_HOT, 32'd3);
		queue_random(200);
		drain();

		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
